// File: rtl/core/dstl_pkg.sv
// Shared definitions for the decimal sample table loader.
// Character codes, result status codes and parameter defaults; no dependencies.

package dstl_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned SampleBitsDefault = 10;
  localparam int unsigned LimitReset        = 558;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_QMARK = 8'd63;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ABORT    = 2'd2
  } status_e;

endpackage

// File: rtl/core/dstl_table.sv
// Waveform sample table: one write port, per-entry valid bits cleared at reset.
// Uses dstl_pkg.

module dstl_table import dstl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  logic [SAMPLE_BITS-1:0]         wr_data_i
);

  logic [SAMPLE_BITS-1:0] mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

// File: rtl/core/dstl_parse.sv
// Character parser: digit accumulator, entry counter and result decode.
// Uses dstl_pkg.

module dstl_parse import dstl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [7:0]                     char_i,
  input  logic [SAMPLE_BITS-1:0]         limit_i,
  output logic                           emit_o,
  output status_e                        status_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] index_o,
  output logic [SAMPLE_BITS-1:0]         value_o,
  output logic                           trimmed_o,
  output logic                           last_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned AccW = SAMPLE_BITS + 1;
  localparam int unsigned ProdW = SAMPLE_BITS + 4;
  localparam logic [AccW-1:0] AccSat = AccW'(1) << SAMPLE_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  logic [AccW-1:0]  acc_q, acc_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] acc_ext, prod;
  logic             is_digit, is_cr, is_qmark, overflow, trim, last;

  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign is_cr    = (char_i == CHAR_CR);
  assign is_qmark = (char_i == CHAR_QMARK);

  // acc * 10 + digit; digit code low nibble is the digit value
  assign acc_ext = ProdW'(acc_q);
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + ProdW'(char_i[3:0]);

  assign overflow = acc_q[SAMPLE_BITS];
  assign trim     = acc_q[SAMPLE_BITS-1:0] > limit_i;
  assign last     = (cnt_q == LastIdx);

  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    emit_o    = 1'b0;
    status_o  = ST_STORED;
    index_o   = '0;
    value_o   = '0;
    trimmed_o = 1'b0;
    last_o    = 1'b0;
    priority if (is_qmark) begin
      acc_d    = '0;
      cnt_d    = '0;
      emit_o   = 1'b1;
      status_o = ST_ABORT;
    end else if (is_digit) begin
      acc_d = (prod > ProdW'(AccSat)) ? AccSat : AccW'(prod);
    end else if (is_cr) begin
      emit_o = 1'b1;
      acc_d  = '0;
      if (overflow) begin
        cnt_d    = '0;
        status_o = ST_OVERFLOW;
      end else begin
        cnt_d     = last ? '0 : cnt_q + IdxW'(1);
        index_o   = cnt_q;
        value_o   = trim ? limit_i : acc_q[SAMPLE_BITS-1:0];
        trimmed_o = trim;
        last_o    = last;
      end
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/decimal_sample_table_loader_top.sv
// Decimal sample table loader, top level.
// Input register, dstl_parse, dstl_table and result register; uses dstl_pkg.

// Accepts one character item per cycle unless a result waits on the output;
// a character waits in the input register, its result in the result register.
// Digits build a value, carriage return stores it (clamped to the limit) in the
// next table entry unless it overflowed, question mark aborts the session. The
// table is cleared at reset through per-entry valid bits, so no clearing pass runs.

module decimal_sample_table_loader_top import dstl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [SAMPLE_BITS-1:0]         cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_char_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] sample_index_o,
  output logic [SAMPLE_BITS-1:0]         stored_value_o,
  output logic                           trimmed_o,
  output logic                           last_sample_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned SampleMax = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned LimitRst = (LimitReset > SampleMax) ? SampleMax : LimitReset;

  logic [SAMPLE_BITS-1:0] limit_q;
  logic                   s1_valid_q;
  logic [7:0]             s1_char_q;
  logic                   out_valid_q;
  logic [1:0]             status_q;
  logic [IdxW-1:0]        index_q;
  logic [SAMPLE_BITS-1:0] value_q;
  logic                   trim_q, last_q;

  logic                   emit, advance, out_free;
  status_e                status;
  logic [IdxW-1:0]        index;
  logic [SAMPLE_BITS-1:0] value;
  logic                   trim, last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SAMPLE_BITS'(LimitRst);
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && (out_free || !emit);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= rx_char_i;
    end
  end

  dstl_parse #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .char_i    (s1_char_q),
    .limit_i   (limit_q),
    .emit_o    (emit),
    .status_o  (status),
    .index_o   (index),
    .value_o   (value),
    .trimmed_o (trim),
    .last_o    (last)
  );

  dstl_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (advance && emit && (status == ST_STORED)),
    .wr_addr_i (index),
    .wr_data_i (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      status_q <= status;
      index_q  <= index;
      value_q  <= value;
      trim_q   <= trim;
      last_q   <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign sample_index_o = index_q;
  assign stored_value_o = value_q;
  assign trimmed_o      = trim_q;
  assign last_sample_o  = last_q;

endmodule
